// ----- rtl/spr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and request codes of the shortest path router.
// No dependencies; the core and the edge memory import this package.
package spr_pkg;

    localparam int NODE_COUNT  = 16;
    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int WEIGHT_BITS = 8;
    localparam int ADDR_BITS   = 2 * NODE_BITS;
    localparam int EDGE_COUNT  = NODE_COUNT * NODE_COUNT;
    // A longest simple path passes every node once; the all-ones code is kept for infinity.
    localparam int DIST_BITS   = 13;
    localparam int MAX_PATH    = 16;
    localparam int SCAN_BITS   = NODE_BITS + 1;
    localparam int ROUND_BITS  = NODE_BITS;
    localparam int STACK_BITS  = $clog2(MAX_PATH);

    typedef logic [NODE_BITS-1:0]   node_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [DIST_BITS-1:0]   dist_t;

    localparam dist_t DIST_INF = {DIST_BITS{1'b1}};

    // Request function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Write port of the edge weight store.
    typedef struct packed {
        logic    en;
        addr_t   addr;
        weight_t data;
    } edge_wr_t;

endpackage

// ----- rtl/spr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the shortest path router: request words in, path words out.
// No dependencies.
interface spr_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] from_node;
    logic [3:0] to_node;
    logic [7:0] edge_weight;

    modport source (output valid, output func, output from_node, output to_node,
                    output edge_weight, input ready);
    modport sink   (input valid, input func, input from_node, input to_node,
                    input edge_weight, output ready);
endinterface

interface spr_path_if;
    logic       valid;
    logic       ready;
    logic [3:0] path_node;
    logic       path_last;

    modport source (output valid, output path_node, output path_last, input ready);
    modport sink   (input valid, input path_node, input path_last, output ready);
endinterface

// ----- rtl/shortest_path_router_core.sv -----
`timescale 1ns / 1ps
// Top level of the shortest path router: sequencer, distance table and path stack.
// Depends on spr_pkg, spr_if (spr_req_if, spr_path_if) and spr_edge_mem.
//
// Usage:
//   req  (sink)   : request words. func = write stores edge_weight at edge
//                   (from_node, to_node), weight 0 removing the edge; func = query
//                   asks for the shortest path from from_node to to_node.
//   path (source) : path words, source node first, path_last set on the destination.
//                   An unreachable destination comes back alone, with path_last set.
// Sequence:
//   A write is accepted while idle and the block stays ready for the next word.
//   A query runs NODE_COUNT-1 rounds, each a settle step then a scan of all nodes
//   through the single edge memory read port (the read is registered, so the
//   scan is one word behind the address). Then the backward walk pushes one path
//   node per cycle and the emit step sends one path word per cycle while the
//   receiver is ready. req.ready is low for the whole query.
// Reset: the edge matrix reads as all zero (no edges), the output is empty and the
//   block is ready for a request.
// Receiver stall: the last path word sits in the output register; while the
//   receiver holds off, the sequencer holds in its emit step and drops nothing.
//   Once the final word is loaded the block takes new requests again.
module shortest_path_router_core
    import spr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spr_req_if.sink    req,
    spr_path_if.source path
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETTLE = 5'b00010,
        ST_RELAX  = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;

    // Working storage of one query.
    dist_t                 dist_reg    [NODE_COUNT];
    node_t                 pred_reg    [NODE_COUNT];
    node_t                 stack_reg   [MAX_PATH];
    logic [NODE_COUNT-1:0] settled_reg;
    logic [NODE_COUNT-1:0] pred_ok_reg;

    // Sequencer registers.
    node_t                 u_reg, u_next;
    dist_t                 du_reg;
    dist_t                 best_reg, best_next;
    node_t                 sel_reg, sel_next;
    logic [SCAN_BITS-1:0]  scan_reg;
    logic                  proc_reg;
    node_t                 vd_reg;
    logic [ROUND_BITS-1:0] round_reg;
    node_t                 dest_reg;
    node_t                 cur_reg;
    logic [STACK_BITS-1:0] cnt_reg;
    logic [STACK_BITS-1:0] emit_idx_reg;

    // Output register.
    logic                  out_valid_reg;
    node_t                 out_node_reg;
    logic                  out_last_reg;

    logic                  req_fire;
    logic                  start_query;
    logic                  scan_done;
    logic                  last_round;
    logic                  walk_stop;
    logic                  out_free;
    logic                  emit_load;

    edge_wr_t              edge_wr;
    addr_t                 edge_rd_addr;
    weight_t               edge_w;

    // Relax / select datapath (the shared compare-and-add unit).
    dist_t                 cur_dist;
    dist_t                 sum;
    logic                  do_relax;
    dist_t                 cand;
    logic                  take;

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign start_query = req_fire && (req.func == FUNC_QUERY);

    assign edge_wr.en   = req_fire && (req.func == FUNC_WRITE);
    assign edge_wr.addr = {req.from_node, req.to_node};
    assign edge_wr.data = req.edge_weight[WEIGHT_BITS-1:0];

    assign edge_rd_addr = {u_reg, scan_reg[NODE_BITS-1:0]};

    spr_edge_mem u_edge_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (edge_wr),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_w)
    );

    // Strict-less relaxation of the node one step behind the read address, then
    // fold the (possibly lowered) distance into the running minimum for the next
    // round. Ties go to the later, higher index.
    always_comb
    begin
        cur_dist  = dist_reg[vd_reg];
        sum       = du_reg + dist_t'(edge_w);
        do_relax  = proc_reg && !settled_reg[vd_reg] && (du_reg != DIST_INF)
                    && (edge_w != '0) && (sum < cur_dist);
        cand      = do_relax ? sum : cur_dist;
        take      = proc_reg && !settled_reg[vd_reg] && (cand <= best_reg);
        best_next = take ? cand : best_reg;
        sel_next  = take ? vd_reg : sel_reg;
    end

    assign scan_done  = (scan_reg == SCAN_BITS'(NODE_COUNT));
    assign last_round = (round_reg == ROUND_BITS'(NODE_COUNT - 2));
    assign walk_stop  = !pred_ok_reg[cur_reg] || (cnt_reg == STACK_BITS'(MAX_PATH - 1));
    assign out_free   = !out_valid_reg || path.ready;
    assign emit_load  = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_query)
                begin
                    state_next = ST_SETTLE;
                    u_next     = req.from_node;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                if (scan_done)
                begin
                    state_next = last_round ? ST_WALK : ST_SETTLE;
                    u_next     = sel_next;
                end
            end
            ST_WALK:
            begin
                if (walk_stop)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (emit_idx_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            u_reg         <= '0;
            scan_reg      <= '0;
            proc_reg      <= 1'b0;
            round_reg     <= '0;
            cnt_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;

            case (state_reg)
                ST_IDLE:
                begin
                    round_reg <= '0;
                end
                ST_SETTLE:
                begin
                    scan_reg <= '0;
                    proc_reg <= 1'b0;
                end
                ST_RELAX:
                begin
                    // Advance the read address; the processed index trails by one.
                    proc_reg <= !scan_done;
                    if (!scan_done)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        round_reg <= round_reg + 1'b1;
                        cnt_reg   <= '0;
                    end
                end
                ST_WALK:
                begin
                    if (walk_stop)
                    begin
                        emit_idx_reg <= cnt_reg;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free && (emit_idx_reg != '0))
                    begin
                        emit_idx_reg <= emit_idx_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (path.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Query working storage; distances and flags are reset as each query starts.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start_query)
                begin
                    for (int v = 0; v < NODE_COUNT; v++)
                    begin
                        dist_reg[v] <= (req.from_node == node_t'(v)) ? '0 : DIST_INF;
                    end
                    settled_reg <= '0;
                    pred_ok_reg <= '0;
                    dest_reg    <= req.to_node;
                end
            end
            ST_SETTLE:
            begin
                settled_reg[u_reg] <= 1'b1;
                du_reg             <= dist_reg[u_reg];
                best_reg           <= DIST_INF;
                sel_reg            <= '0;
            end
            ST_RELAX:
            begin
                best_reg <= best_next;
                sel_reg  <= sel_next;
                if (do_relax)
                begin
                    dist_reg[vd_reg]    <= sum;
                    pred_reg[vd_reg]    <= u_reg;
                    pred_ok_reg[vd_reg] <= 1'b1;
                end
                if (scan_done)
                begin
                    cur_reg <= dest_reg;
                end
            end
            ST_WALK:
            begin
                // Push the current node and step back along the predecessors.
                stack_reg[cnt_reg] <= cur_reg;
                cur_reg            <= pred_reg[cur_reg];
            end
            default:
            begin
            end
        endcase

        vd_reg <= scan_reg[NODE_BITS-1:0];

        if (emit_load)
        begin
            out_node_reg <= stack_reg[emit_idx_reg];
            out_last_reg <= (emit_idx_reg == '0);
        end
    end

    assign path.valid     = out_valid_reg;
    assign path.path_node = out_node_reg;
    assign path.path_last = out_last_reg;

endmodule

// ----- rtl/spr_edge_mem.sv -----
`timescale 1ns / 1ps
// Adjacency matrix store: one write port, one registered read port.
// Depends on spr_pkg. Per-entry valid bits make never-written edges read as zero.
module spr_edge_mem
    import spr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  edge_wr_t wr,
    input  addr_t    rd_addr,
    output weight_t  rd_data
);

    weight_t                 mem [EDGE_COUNT];
    logic [EDGE_COUNT-1:0]   valid_reg;
    weight_t                 data_reg;
    logic                    hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule
